/* rtl/core/linear_congruence_solver_assert.svh */
// Assertion macros for the linear congruence solver
`ifndef LINEAR_CONGRUENCE_SOLVER_ASSERT_SVH
`define LINEAR_CONGRUENCE_SOLVER_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define LCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication
`define LCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/lcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared constants and types of the linear congruence solver.
// ----------------------------------------------------------------------------
package lcs_pkg;
	localparam int unsigned LcsWidth = 32;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_GCD_START,
		ST_GCD_WAIT,
		ST_BCHK_START,
		ST_BCHK_WAIT,
		ST_AR_START,
		ST_AR_WAIT,
		ST_BR_START,
		ST_BR_WAIT,
		ST_MR_START,
		ST_MR_WAIT,
		ST_ARM_START,
		ST_ARM_WAIT,
		ST_EE_CHECK,
		ST_EE_WAIT,
		ST_EE_MUL,
		ST_BRM_START,
		ST_BRM_WAIT,
		ST_FMUL,
		ST_OUT
	} seq_state_t;
endpackage

/* rtl/core/lcs_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_divider
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module lcs_divider #(
	parameter int unsigned WIDTH = lcs_pkg::LcsWidth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quotient,
	output logic [WIDTH-1:0] remainder
);
	import lcs_pkg::*;

	localparam int unsigned CntW = $clog2(WIDTH + 1);

	div_state_t       state_q;
	logic [CntW-1:0]  cnt_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dsr_q;
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;

	assign trial = {rem_q, quo_q[WIDTH-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				DIV_IDLE: begin
					if (start) begin
						state_q <= DIV_RUN;
						cnt_q   <= CntW'(WIDTH);
					end
				end
				DIV_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CntW'(1)) state_q <= DIV_DONE;
				end
				DIV_DONE: state_q <= DIV_IDLE;
				default:  state_q <= DIV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (state_q == DIV_RUN) begin
			if (!diff[WIDTH]) begin
				rem_q <= diff[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= trial[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done      = (state_q == DIV_DONE);
	assign quotient  = quo_q;
	assign remainder = rem_q;

	`include "linear_congruence_solver_assert.svh"
	`LCS_ASSERT_NEXT(a_div_run_after_start, clk, arst_n, state_q == DIV_IDLE && start, state_q == DIV_RUN)
	`LCS_ASSERT_IMP(a_div_cnt_range, clk, arst_n, state_q == DIV_RUN, cnt_q != '0)
	`LCS_ASSERT_NEXT(a_div_done_pulse, clk, arst_n, done, !done)
endmodule

/* rtl/core/lcs_mulmod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_mulmod
// Shift-and-add modular multiplier, one bit of y per cycle, x and y below m.
// ----------------------------------------------------------------------------
module lcs_mulmod #(
	parameter int unsigned WIDTH = lcs_pkg::LcsWidth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] x,
	input  logic [WIDTH-1:0] y,
	input  logic [WIDTH-1:0] m,
	output logic             done,
	output logic [WIDTH-1:0] prod
);
	import lcs_pkg::*;

	localparam int unsigned CntW = $clog2(WIDTH + 1);

	div_state_t       state_q;
	logic [CntW-1:0]  cnt_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] x_q;
	logic [WIDTH-1:0] y_q;
	logic [WIDTH-1:0] m_q;
	logic [WIDTH:0]   dbl;
	logic [WIDTH-1:0] acc2;
	logic [WIDTH:0]   sum;
	logic [WIDTH-1:0] acc3;

	// values below m, so one conditional subtract reduces each add
	always_comb begin
		dbl  = {acc_q, 1'b0};
		acc2 = (dbl >= {1'b0, m_q}) ? WIDTH'(dbl - {1'b0, m_q}) : dbl[WIDTH-1:0];
		sum  = {1'b0, acc2} + {1'b0, x_q};
		if (y_q[WIDTH-1])
			acc3 = (sum >= {1'b0, m_q}) ? WIDTH'(sum - {1'b0, m_q}) : sum[WIDTH-1:0];
		else
			acc3 = acc2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				DIV_IDLE: begin
					if (start) begin
						state_q <= DIV_RUN;
						cnt_q   <= CntW'(WIDTH);
					end
				end
				DIV_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CntW'(1)) state_q <= DIV_DONE;
				end
				DIV_DONE: state_q <= DIV_IDLE;
				default:  state_q <= DIV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
			m_q   <= m;
		end else if (state_q == DIV_RUN) begin
			acc_q <= acc3;
			y_q   <= {y_q[WIDTH-2:0], 1'b0};
		end
	end

	assign done = (state_q == DIV_DONE);
	assign prod = acc_q;

	`include "linear_congruence_solver_assert.svh"
	`LCS_ASSERT_IMP(a_mm_acc_below_m, clk, arst_n, state_q == DIV_RUN, acc_q < m_q)
	`LCS_ASSERT_NEXT(a_mm_done_pulse, clk, arst_n, done, !done)
	`LCS_ASSERT_NEXT(a_mm_run_after_start, clk, arst_n, state_q == DIV_IDLE && start, state_q == DIV_RUN)
endmodule

/* rtl/core/linear_congruence_solver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_congruence_solver
// Solves coeff*x = rhs (mod modulus) with gcd and extended Euclid.
// ----------------------------------------------------------------------------
// Usage: one input transfer (coeff, rhs, modulus) gives one output transfer
// (solvable, base_solution, step). Valid/stall handshake on both sides.
// One item at a time: in_stall is high from acceptance until the result is
// taken. A single shared restoring divider runs the gcd, the divisibility
// test, the three reductions by the gcd, the two reductions mod m and each
// Euclid quotient; a shift-add modular multiplier forms q*t and the final
// product. Unsolvable items finish after the divisibility test.
// Reset clears the sequencer; no item is in flight after it. While the
// receiver stalls, the result is held on the ports and no new item is taken.
// Unsolvable items and a zero modulus return all zeros.
// ----------------------------------------------------------------------------
module linear_congruence_solver #(
	parameter int unsigned WIDTH = lcs_pkg::LcsWidth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [WIDTH-1:0] coeff,
	input  logic [WIDTH-1:0] rhs,
	input  logic [WIDTH-1:0] modulus,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             solvable,
	output logic [WIDTH-1:0] base_solution,
	output logic [WIDTH-1:0] step
);
	import lcs_pkg::*;

	seq_state_t state_q, state_d;

	logic [WIDTH-1:0] a_q, b_q, m_q, g_q, r0_q, r1_q, t0_q, t1_q, ar_q, br_q;
	logic             sol_q;

	logic             dv_start, mm_start, dv_done, mm_done;
	logic [WIDTH-1:0] dv_n, dv_d, dv_quo, dv_rem, mm_x, mm_y, mm_m, mm_p;
	logic [WIDTH-1:0] tn;

	lcs_divider #(.WIDTH(WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_n),
		.divisor(dv_d), .done(dv_done), .quotient(dv_quo), .remainder(dv_rem)
	);

	lcs_mulmod #(.WIDTH(WIDTH)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mm_start), .x(mm_x), .y(mm_y),
		.m(mm_m), .done(mm_done), .prod(mm_p)
	);

	// t0 - p mod m
	assign tn = (t0_q >= mm_p) ? (t0_q - mm_p) : (t0_q + (m_q - mm_p));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:       if (in_valid) state_d = ST_GCD_START;
			ST_GCD_START: begin
				if (m_q == '0)      state_d = ST_OUT;
				else if (r1_q == '0) state_d = ST_BCHK_START;
				else                state_d = ST_GCD_WAIT;
			end
			ST_GCD_WAIT:   if (dv_done) state_d = ST_GCD_START;
			ST_BCHK_START: state_d = ST_BCHK_WAIT;
			ST_BCHK_WAIT:  if (dv_done) state_d = (dv_rem == '0) ? ST_AR_START : ST_OUT;
			ST_AR_START:   state_d = ST_AR_WAIT;
			ST_AR_WAIT:    if (dv_done) state_d = ST_BR_START;
			ST_BR_START:   state_d = ST_BR_WAIT;
			ST_BR_WAIT:    if (dv_done) state_d = ST_MR_START;
			ST_MR_START:   state_d = ST_MR_WAIT;
			ST_MR_WAIT:    if (dv_done) state_d = ST_ARM_START;
			ST_ARM_START:  state_d = (m_q == WIDTH'(1)) ? ST_OUT : ST_ARM_WAIT;
			ST_ARM_WAIT:   if (dv_done) state_d = ST_EE_CHECK;
			ST_EE_CHECK:   state_d = (r1_q == '0) ? ST_BRM_START : ST_EE_WAIT;
			ST_EE_WAIT:    if (dv_done) state_d = ST_EE_MUL;
			ST_EE_MUL:     if (mm_done) state_d = ST_EE_CHECK;
			ST_BRM_START:  state_d = ST_BRM_WAIT;
			ST_BRM_WAIT:   if (dv_done) state_d = ST_FMUL;
			ST_FMUL:       if (mm_done) state_d = ST_OUT;
			ST_OUT:        if (!out_stall) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// q can equal m on the first Euclid step (r1 = 1); the multiplier still
	// reduces that correctly since q*t is then 0 mod m
	always_comb begin
		dv_start = 1'b0;
		dv_n     = r0_q;
		dv_d     = r1_q;
		mm_start = 1'b0;
		mm_x     = dv_quo;
		mm_y     = t1_q;
		mm_m     = m_q;
		case (state_q)
			ST_GCD_START: dv_start = (m_q != '0) && (r1_q != '0);
			ST_BCHK_START: begin dv_start = 1'b1; dv_n = b_q; dv_d = g_q; end
			ST_AR_START:   begin dv_start = 1'b1; dv_n = a_q; dv_d = g_q; end
			ST_BR_START:   begin dv_start = 1'b1; dv_n = b_q; dv_d = g_q; end
			ST_MR_START:   begin dv_start = 1'b1; dv_n = m_q; dv_d = g_q; end
			ST_ARM_START: begin
				dv_start = (m_q != WIDTH'(1)); dv_n = ar_q; dv_d = m_q;
			end
			ST_EE_CHECK:   dv_start = (r1_q != '0);
			ST_EE_WAIT:    mm_start = dv_done;
			ST_BRM_START:  begin dv_start = 1'b1; dv_n = br_q; dv_d = m_q; end
			ST_BRM_WAIT:   begin mm_start = dv_done; mm_x = t0_q; mm_y = dv_rem; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					a_q   <= coeff;
					b_q   <= rhs;
					m_q   <= modulus;
					r0_q  <= modulus;
					r1_q  <= coeff;
					sol_q <= 1'b0;
					t0_q  <= '0;
					g_q   <= '0;
				end
			end
			ST_GCD_START: if (r1_q == '0) g_q <= r0_q;
			ST_GCD_WAIT: if (dv_done) begin r0_q <= r1_q; r1_q <= dv_rem; end
			ST_BCHK_WAIT: if (dv_done && dv_rem != '0) begin
				m_q <= '0; t0_q <= '0;
			end
			ST_AR_WAIT:  if (dv_done) ar_q <= dv_quo;
			ST_BR_WAIT:  if (dv_done) br_q <= dv_quo;
			ST_MR_WAIT: if (dv_done) begin m_q <= dv_quo; sol_q <= 1'b1; t0_q <= '0; end
			ST_ARM_WAIT: if (dv_done) begin
				r0_q <= m_q; r1_q <= dv_rem; t0_q <= '0; t1_q <= WIDTH'(1);
			end
			// divider is idle here and still holds r0 mod r1
			ST_EE_MUL: if (mm_done) begin
				r0_q <= r1_q;
				r1_q <= dv_rem;
				t0_q <= t1_q;
				t1_q <= tn;
			end
			ST_FMUL: if (mm_done) t0_q <= mm_p;
			default: ;
		endcase
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = (state_q == ST_OUT);
	assign solvable      = sol_q;
	assign base_solution = sol_q ? t0_q : '0;
	assign step          = sol_q ? m_q : '0;

	`include "linear_congruence_solver_assert.svh"
	`LCS_ASSERT_IMP(a_out_held, clk, arst_n, out_valid && out_stall, ##1 out_valid)
	`LCS_ASSERT_IMP(a_no_take_busy, clk, arst_n, out_valid, in_stall)
	`LCS_ASSERT_IMP(a_sol_below_step, clk, arst_n, out_valid && solvable, base_solution < step || step == WIDTH'(1))
endmodule

/* bench/tb_linear_congruence_solver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_congruence_solver
// Self-checking bench for the linear congruence solver. A directed table of
// edge cases (zero coefficient, unit modulus, no solution, full-range values)
// is followed by random items, most of them built with a chosen common factor.
// Every result is compared with the table's expected value or with a local
// gcd / extended Euclid predictor. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module tb_linear_congruence_solver;
	import lcs_pkg::*;

	localparam int W = LcsWidth;
	localparam int NUM_RANDOM = 1800;
	localparam longint MAX_CYCLES = 64'd40_000_000;

	typedef struct packed {
		logic         solvable;
		logic [W-1:0] base_solution;
		logic [W-1:0] step;
	} solution_t;

	typedef struct {
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W-1:0] m;
		logic         known;
		solution_t    sol;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [W-1:0] coeff = '0;
	logic [W-1:0] rhs = '0;
	logic [W-1:0] modulus = 1;
	logic out_valid;
	logic out_stall = 1'b0;
	logic solvable;
	logic [W-1:0] base_solution;
	logic [W-1:0] step;

	solution_t expected_solutions[$];
	int mismatches = 0;
	bit stim_done = 1'b0;
	longint cycles = 0;

	linear_congruence_solver DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.coeff(coeff), .rhs(rhs), .modulus(modulus),
		.out_valid(out_valid), .out_stall(out_stall),
		.solvable(solvable), .base_solution(base_solution), .step(step)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
		longint unsigned r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// products fit in 64 bits since operands are below 2^32
	function automatic solution_t solve_congruence(logic [W-1:0] a, logic [W-1:0] b,
			logic [W-1:0] m);
		solution_t s;
		longint unsigned g, ar, br, mr, r0, r1, t0, t1, q, rn, tn, qt;
		s = '0;
		if (m == 0) return s;
		g = gcd_of(64'(a), 64'(m));
		if (64'(b) % g != 0) return s;
		ar = 64'(a) / g;
		br = 64'(b) / g;
		mr = 64'(m) / g;
		s.solvable = 1'b1;
		s.step = mr[W-1:0];
		if (mr == 1) return s;
		r0 = mr;
		r1 = ar % mr;
		t0 = 0;
		t1 = 1;
		while (r1 != 0) begin
			q = r0 / r1;
			rn = r0 - q * r1;
			qt = ((q % mr) * t1) % mr;
			tn = (t0 >= qt) ? t0 - qt : t0 + (mr - qt);
			r0 = r1;
			r1 = rn;
			t0 = t1;
			t1 = tn;
		end
		s.base_solution = W'((t0 * (br % mr)) % mr);
		return s;
	endfunction

	task automatic send_item(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] m);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		coeff <= a;
		rhs <= b;
		modulus <= m;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic [W-1:0] rand_word();
		case ($urandom_range(0, 4))
			0: return W'($urandom_range(0, 20));
			1: return '1 - W'($urandom_range(0, 20));
			2: return W'($urandom_range(0, 65535));
			default: return W'($urandom);
		endcase
	endfunction

	// stimulus
	initial begin
		vector_t table_rows[$];
		vector_t v;
		logic [W-1:0] g, a, b, m;
		solution_t zero_sol, unit_sol;
		zero_sol = '0;
		unit_sol = '{solvable: 1'b1, base_solution: '0, step: 1};
		table_rows = '{
			'{0, 0, 1, 1'b1, unit_sol},
			'{0, 5, 1, 1'b1, unit_sol},
			'{'1, '1, 1, 1'b1, unit_sol},
			'{0, 0, 7, 1'b1, unit_sol},
			'{0, 14, 7, 1'b1, unit_sol},
			'{0, 3, 7, 1'b0, zero_sol},
			'{4, 3, 6, 1'b1, zero_sol},
			'{6, 5, 9, 1'b1, zero_sol},
			'{0, '1, '1, 1'b1, unit_sol},
			'{'1, 1, '1, 1'b1, zero_sol},
			'{'1, 1, 32'hFFFF_FFFE, 1'b0, zero_sol},
			'{3, 1, 7, 1'b0, zero_sol},
			'{'1, '1, 32'hFFFF_FFFE, 1'b0, zero_sol},
			'{1, '1, 32'hFFFF_FFFB, 1'b0, zero_sol},
			'{32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, zero_sol},
			'{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, zero_sol},
			'{32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 1'b0, zero_sol},
			'{32'h6000_0000, 32'h2000_0000, 32'h8000_0000, 1'b0, zero_sol},
			'{32'hB504_F333, 32'h9E37_79B9, 32'hFFFF_FFFB, 1'b0, zero_sol},
			'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, zero_sol}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		foreach (table_rows[i]) begin
			v = table_rows[i];
			expected_solutions.push_back(v.known ? v.sol : solve_congruence(v.a, v.b, v.m));
			send_item(v.a, v.b, v.m);
		end
		for (int n = 0; n < NUM_RANDOM; n++) begin
			m = rand_word();
			if (m == 0) m = 1;
			a = rand_word();
			b = rand_word();
			if ($urandom_range(0, 3) != 0) begin
				// force a common factor so solvable items with g > 1 are common
				g = W'($urandom_range(1, 12));
				m = (m / g == 0) ? g : (m / g) * g;
				a = (a / g) * g;
				b = (b / g) * g;
			end
			expected_solutions.push_back(solve_congruence(a, b, m));
			send_item(a, b, m);
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver stalls
	initial begin
		int gap;
		forever begin
			@(posedge clk);
			if (out_stall) begin
				if (gap > 0) gap--;
				else out_stall <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 80) : $urandom_range(0, 3);
				out_stall <= 1'b1;
			end
		end
	end

	// result check
	always @(posedge clk) begin
		solution_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_solutions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: %b %h %h",
						solvable, base_solution, step);
			end else begin
				want = expected_solutions.pop_front();
				if (solvable !== want.solvable || base_solution !== want.base_solution ||
						step !== want.step) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %b %h %h got %b %h %h",
							want.solvable, want.base_solution, want.step,
							solvable, base_solution, step);
				end
			end
		end
	end

	// end of run
	initial begin
		while (!(stim_done && expected_solutions.size() == 0) && cycles < MAX_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= MAX_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
		end else begin
			repeat (200) @(posedge clk);
			if (mismatches == 0)
				$display("Testbench completed without errors");
			else
				$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
